// ===== rtl/wifi_data_frame_deframer_top_defines.svh =====
// Assertion macros for the 802.11 data frame deframer.
// Used by the top level only; the bodies are empty when SYNTH is defined.
`ifndef WIFI_DATA_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WIFI_DATA_FRAME_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTH
`define WDF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
`define WDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define WDF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define WDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/wdf_pkg.sv =====
// Shared types and constants of the 802.11 data frame deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package wdf_pkg;

  typedef logic [4:0]  pos_t;
  typedef logic [7:0]  byte_t;
  typedef logic [47:0] bssid_t;

  localparam pos_t PlainHdrLen = 5'd24;
  localparam pos_t QosHdrLen   = 5'd26;

  localparam pos_t DaFirst    = 5'd4;
  localparam pos_t DaLast     = 5'd9;
  localparam pos_t BssidFirst = 5'd16;
  localparam pos_t BssidLast  = 5'd21;

  localparam byte_t TypeMask     = 8'h0C;
  localparam byte_t TypeData     = 8'h08;
  localparam byte_t SubtypeMask  = 8'hF0;
  localparam byte_t SubtypeQos   = 8'h80;
  localparam byte_t SubtypePlain = 8'h00;
  localparam byte_t BcastByte    = 8'hFF;

  typedef struct packed {
    byte_t payload_byte;
    logic  payload_valid;
    logic  frame_done;
    logic  accepted;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/wdf_in_stage.sv =====
// Input register of the deframer with its stall logic.
// Uses wdf_pkg for the byte type.
`default_nettype none

module wdf_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire wdf_pkg::byte_t frame_byte_i,
  input  wire logic          frame_end_i,
  input  wire logic          advance_i,
  output logic               valid_o,
  output wdf_pkg::byte_t     frame_byte_o,
  output logic               frame_end_o
);

  logic           valid_q, valid_d;
  logic           load;
  wdf_pkg::byte_t byte_q;
  logic           end_q;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= frame_byte_i;
      end_q  <= frame_end_i;
    end
  end

  assign valid_o      = valid_q;
  assign frame_byte_o = byte_q;
  assign frame_end_o  = end_q;

endmodule

`default_nettype wire

// ===== rtl/wdf_parse.sv =====
// Header checker and payload strip: frame state and the per-byte decision.
// Uses wdf_pkg for constants and the result type.
`default_nettype none

module wdf_parse (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire wdf_pkg::bssid_t bssid_i,
  input  wire wdf_pkg::byte_t  frame_byte_i,
  input  wire logic            frame_end_i,
  input  wire logic            advance_i,
  output wdf_pkg::result_t     res_o,
  output logic                 has_result_o
);

  wdf_pkg::pos_t pos_q, pos_d;
  logic          qos_q, qos_d;
  logic          rej_q, rej_d;

  logic          first_byte;
  logic          type_ok;
  logic          sub_qos;
  logic          sub_plain;
  logic          qos_n;
  logic          rej_first;
  wdf_pkg::pos_t hdr_len;
  logic          is_payload;
  logic          in_da;
  logic          in_bssid;
  wdf_pkg::pos_t bssid_sel;
  logic [5:0]    bssid_amt;
  wdf_pkg::bssid_t bssid_shift;
  logic          hdr_fail;
  logic          rej_n;
  logic          emit;
  logic          hdr_done;

  assign first_byte = (pos_q == '0);
  assign type_ok    = (frame_byte_i & wdf_pkg::TypeMask) == wdf_pkg::TypeData;
  assign sub_qos    = (frame_byte_i & wdf_pkg::SubtypeMask) == wdf_pkg::SubtypeQos;
  assign sub_plain  = (frame_byte_i & wdf_pkg::SubtypeMask) == wdf_pkg::SubtypePlain;

  assign qos_n     = qos_q || (first_byte && type_ok && sub_qos);
  assign rej_first = first_byte && (!type_ok || (!sub_qos && !sub_plain));

  assign hdr_len    = qos_n ? wdf_pkg::QosHdrLen : wdf_pkg::PlainHdrLen;
  assign is_payload = (pos_q >= hdr_len);

  assign in_da     = (pos_q >= wdf_pkg::DaFirst) && (pos_q <= wdf_pkg::DaLast);
  assign in_bssid  = (pos_q >= wdf_pkg::BssidFirst) && (pos_q <= wdf_pkg::BssidLast);
  assign bssid_sel = wdf_pkg::BssidLast - pos_q;
  assign bssid_amt = {bssid_sel[2:0], 3'b000};
  assign bssid_shift = bssid_i >> bssid_amt;

  always_comb begin
    hdr_fail = 1'b0;
    if (!is_payload && !first_byte) begin
      if (in_da) begin
        hdr_fail = (frame_byte_i != wdf_pkg::BcastByte);
      end else if (in_bssid) begin
        hdr_fail = (bssid_shift[7:0] != frame_byte_i);
      end
    end
  end

  assign rej_n    = rej_q || rej_first || hdr_fail;
  assign emit     = is_payload && !rej_n;
  assign hdr_done = ({1'b0, pos_q} + 6'd1) >= {1'b0, hdr_len};

  always_comb begin
    res_o.payload_byte  = emit ? frame_byte_i : '0;
    res_o.payload_valid = emit;
    res_o.frame_done    = frame_end_i;
    res_o.accepted      = frame_end_i && !rej_n && hdr_done;
  end

  assign has_result_o = frame_end_i || emit;

  always_comb begin
    pos_d = pos_q;
    qos_d = qos_q;
    rej_d = rej_q;
    if (advance_i) begin
      if (frame_end_i) begin
        pos_d = '0;
        qos_d = 1'b0;
        rej_d = 1'b0;
      end else begin
        pos_d = (pos_q < wdf_pkg::QosHdrLen) ? pos_q + 5'd1 : pos_q;
        qos_d = qos_n;
        rej_d = rej_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      qos_q <= 1'b0;
      rej_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      qos_q <= qos_d;
      rej_q <= rej_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wifi_data_frame_deframer_top.sv =====
// Top level of the 802.11 data frame deframer: BSSID register and result register.
// Instantiates wdf_in_stage and wdf_parse; uses wdf_pkg and the assertion macros.
`default_nettype none

`include "wifi_data_frame_deframer_top_defines.svh"

// The deframer takes one MPDU byte per transfer and sustains one byte per
// cycle while the output is not stalled. Each byte is captured in an input
// register, checked and classified combinationally against the frame state,
// and its result, if any, is held in an output register. Header bytes that
// are not final give no result; payload bytes of an accepted frame and every
// final byte give one. The BSSID register should only be written while no
// frame byte is in flight.
module wifi_data_frame_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [47:0] bssid_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       payload_byte_o,
  output logic             payload_valid_o,
  output logic             frame_done_o,
  output logic             accepted_o
);

  wdf_pkg::bssid_t  bssid_q;
  logic             s1_valid;
  wdf_pkg::byte_t   s1_byte;
  logic             s1_end;
  logic             advance;
  logic             out_ready;
  logic             has_result;
  wdf_pkg::result_t res;
  logic             out_load;
  logic             out_valid_q, out_valid_d;
  wdf_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bssid_q <= '0;
    end else if (cfg_we_i) begin
      bssid_q <= bssid_i;
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;
  assign advance   = s1_valid && (!has_result || out_ready);
  assign out_load  = advance && has_result;
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  wdf_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_byte_i (frame_byte_i),
    .frame_end_i  (frame_end_i),
    .advance_i    (advance),
    .valid_o      (s1_valid),
    .frame_byte_o (s1_byte),
    .frame_end_o  (s1_end)
  );

  wdf_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bssid_i      (bssid_q),
    .frame_byte_i (s1_byte),
    .frame_end_i  (s1_end),
    .advance_i    (advance),
    .res_o        (res),
    .has_result_o (has_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = res_q.payload_byte;
  assign payload_valid_o = res_q.payload_valid;
  assign frame_done_o    = res_q.frame_done;
  assign accepted_o      = res_q.accepted;

  `WDF_ASSERT_IMPLIES(a_mid_result_is_payload, clk_i, rst_ni,
    out_valid_q && !res_q.frame_done, res_q.payload_valid)
  `WDF_ASSERT_IMPLIES(a_verdict_only_at_end, clk_i, rst_ni,
    out_valid_q && res_q.accepted, res_q.frame_done)
  `WDF_ASSERT_IMPLIES(a_stall_only_when_full, clk_i, rst_ni,
    in_stall_o, s1_valid && has_result && out_valid_q && out_stall_i)
  `WDF_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni,
    out_load, out_valid_q)

endmodule

`default_nettype wire
